FILE: rtl/adaptive_key_value_range_table_macros.svh
// assertion macros for the key-value range table
`ifndef ADAPTIVE_KEY_VALUE_RANGE_TABLE_MACROS_SVH
`define ADAPTIVE_KEY_VALUE_RANGE_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define AKV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AKV_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AKV_ASSERT(label, clk, rst_n, prop, msg)
`define AKV_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: rtl/akvrt_pkg.sv
// ----------------------------------------------------------------------------
// akvrt_pkg
// types and constants shared by the key-value range table modules
// ----------------------------------------------------------------------------
package akvrt_pkg;

    localparam int unsigned MAX_OUT   = 32;
    localparam logic [23:0] SCORE_MAX = 24'hFFFFFF;
    localparam logic [23:0] ONE_Q16   = 24'd65536;
    localparam logic [15:0] DECAY_Q16 = 16'd62259;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_FIND   = 2'd1,
        K_RANGE  = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DECAY_P,
        S_DECAY_R,
        S_LOG,
        S_CMP_A,
        S_CMP_B,
        S_CMP_C,
        S_CMP_D,
        S_CHECK,
        S_EMIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        M_DECAY,
        M_SQUARE,
        M_PR_LOG,
        M_R_N_LO,
        M_R_N_HI
    } t_mop;

    typedef struct packed {
        logic        go;
        t_mop        op;
    } t_mul_ctl;

endpackage

FILE: rtl/akvrt_mul.sv
// ----------------------------------------------------------------------------
// akvrt_mul
// shared registered 32x32 multiplier used by the sequencer for decay,
// log2 squaring and the mode switch products
// ----------------------------------------------------------------------------
module akvrt_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;
endmodule

FILE: rtl/adaptive_key_value_range_table.sv
// ----------------------------------------------------------------------------
// adaptive_key_value_range_table
// sorted key-value table with insert, find and range query, and a
// workload-driven hash/ordered mode flag
// ----------------------------------------------------------------------------
// One item at a time. Ready is low from the accepting edge until the last
// result beat of the item has been taken, then the next item is taken in the
// idle state. An item goes through the position scan (pos = entries below
// the key, at most n), the shift when an insert adds a new key, the score
// decay, the 16-step log2 and the mode check, all run through one shared
// registered multiplier, then the load of the first result beat, then one
// result beat per cycle while the receiver takes them, fewer while it stalls
// (n = current entry count).
module adaptive_key_value_range_table #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_data_value,
    input  logic signed [31:0] i_range_high,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit,
    output logic signed [31:0] o_out_key,
    output logic signed [31:0] o_out_value,
    output logic               o_last,
    output logic               o_ordered_mode,
    output logic               o_table_full
);
    import akvrt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] r_keys [CAPACITY];
    logic signed [31:0] r_vals [CAPACITY];

    t_state             r_state, n_state;
    t_kind              r_kind;
    logic signed [31:0] r_key, r_val, r_high;
    logic [CW-1:0]      r_count, r_pos, r_idx;
    logic               r_found, r_full;
    logic [23:0]        r_ps, r_rs;
    logic               r_mode;
    logic [31:0]        r_y;
    logic [22:0]        r_log;
    logic [4:0]         r_step;
    logic [63:0]        r_lhs, r_rhs;
    logic [5:0]         r_nout;
    logic               r_wait;

    logic               r_ov, r_hit, r_last, r_tf;
    logic signed [31:0] r_ok, r_oval;

    logic [31:0] w_a, w_b;
    logic [63:0] w_p;
    logic [CW-1:0] w_n;
    logic [2:0] w_ip;
    logic signed [31:0] w_k;
    logic w_out_free;
    logic w_hit;
    logic w_emit;
    logic [23:0] w_dec, w_bump;

    akvrt_mul u_mul (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .o_p(w_p));

    assign w_n = (r_count == '0) ? CW'(1) : r_count;
    assign w_out_free = !r_ov || i_ready;
    assign w_k = r_keys[r_idx[AW-1:0]];
    assign w_hit = (r_pos < r_count) && (w_k == r_key);
    assign w_emit = (r_state == S_EMIT || (r_state == S_OUT && r_kind == K_RANGE && !r_last))
                    && w_out_free;
    assign w_dec = 24'((w_p + 64'd32768) >> 16);
    assign w_bump = ({1'b0, w_dec} + {1'b0, ONE_Q16} > {1'b0, SCORE_MAX}) ? SCORE_MAX
                                                                          : w_dec + ONE_Q16;

    always_comb begin
        w_ip = 3'd0;
        for (int i = 1; i < 7; i++) begin
            if ((32'(w_n) >> i) != 32'd0) w_ip = 3'(i);
        end
    end

    always_comb begin
        w_a = 32'd0;
        w_b = 32'd0;
        case (r_state)
            S_DECAY_P: begin w_a = {8'd0, r_ps}; w_b = {16'd0, DECAY_Q16}; end
            S_DECAY_R: begin w_a = {8'd0, r_rs}; w_b = {16'd0, DECAY_Q16}; end
            S_LOG:     begin w_a = r_y; w_b = r_y; end
            S_CMP_A:   begin w_a = {7'd0, {1'b0, r_ps} + {1'b0, r_rs}}; w_b = {9'd0, r_log}; end
            S_CMP_B:   begin w_a = {8'd0, r_rs}; w_b = 32'(w_n); end
            default:   ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = (t_kind'(i_kind) == K_NONE) ? S_IDLE : S_SCAN;
            S_SCAN:  if (r_pos >= r_count || w_k >= r_key) n_state = S_SHIFT;
            S_SHIFT: if (r_idx == r_pos) n_state = S_DECAY_P;
            S_DECAY_P: if (r_wait) n_state = S_DECAY_R;
            S_DECAY_R: if (r_wait) n_state = S_LOG;
            S_LOG:   if (r_wait && r_step == 5'd1) n_state = S_CMP_A;
            S_CMP_A: if (r_wait) n_state = S_CMP_B;
            S_CMP_B: if (r_wait) n_state = S_CHECK;
            S_CHECK: n_state = S_EMIT;
            S_EMIT:  n_state = S_OUT;
            S_OUT:   if (w_out_free) begin
                if (r_kind != K_RANGE || r_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ps    <= '0;
            r_rs    <= '0;
            r_mode  <= 1'b0;
            r_ov    <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_kind <= t_kind'(i_kind);
                    r_key  <= i_key;
                    r_val  <= i_data_value;
                    r_high <= i_range_high;
                    r_pos  <= '0;
                    r_idx  <= '0;
                    r_wait <= 1'b0;
                end
                S_SCAN: begin
                    if (r_pos >= r_count || w_k >= r_key) begin
                        r_found <= w_hit;
                        r_full  <= (r_kind == K_INSERT) && !w_hit
                                   && (r_count >= CW'(CAPACITY));
                        if (r_kind == K_INSERT && !w_hit && r_count < CW'(CAPACITY))
                            r_idx <= r_count;
                        else
                            r_idx <= r_pos;
                        if (r_kind == K_INSERT && w_hit)
                            r_vals[r_pos[AW-1:0]] <= r_val;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                        r_idx <= r_pos + 1'b1;
                    end
                end
                S_SHIFT: begin
                    if (r_idx == r_pos) begin
                        if (r_kind == K_INSERT && !r_found && !r_full) begin
                            r_keys[r_pos[AW-1:0]] <= r_key;
                            r_vals[r_pos[AW-1:0]] <= r_val;
                            r_count <= r_count + 1'b1;
                        end
                    end else begin
                        r_keys[r_idx[AW-1:0]] <= r_keys[r_idx[AW-1:0] - 1'b1];
                        r_vals[r_idx[AW-1:0]] <= r_vals[r_idx[AW-1:0] - 1'b1];
                        r_idx <= r_idx - 1'b1;
                    end
                end
                S_DECAY_P: begin
                    r_wait <= !r_wait;
                    if (r_wait) r_ps <= (r_kind == K_FIND) ? w_bump : w_dec;
                end
                S_DECAY_R: begin
                    r_wait <= !r_wait;
                    if (r_wait) begin
                        r_rs   <= (r_kind == K_RANGE) ? w_bump : w_dec;
                        r_y    <= 32'(64'(w_n) << (30 - 32'(w_ip)));
                        r_log  <= {20'(w_ip), 3'd0} << 13;
                        r_step <= 5'd16;
                    end
                end
                S_LOG: begin
                    r_wait <= !r_wait;
                    if (r_wait) begin
                        if ((w_p >> 30) >= 64'h8000_0000) begin
                            r_y <= 32'(w_p >> 31);
                            r_log[{1'b0, r_step[3:0] - 4'd1}] <= 1'b1;
                        end else begin
                            r_y <= 32'(w_p >> 30);
                        end
                        r_step <= r_step - 1'b1;
                    end
                end
                S_CMP_A: begin
                    r_wait <= !r_wait;
                    if (r_wait) r_lhs <= w_p + (64'(w_n) << 32);
                end
                S_CMP_B: begin
                    r_wait <= !r_wait;
                    if (r_wait) r_rhs <= (64'(r_ps) << 16) + (w_p << 16);
                end
                S_CHECK: begin
                    if (r_lhs < r_rhs) r_mode <= 1'b1;
                    r_idx  <= r_pos;
                    r_nout <= '0;
                end
                default: ;
            endcase
            if (w_emit) begin
                r_ov <= 1'b1;
                case (r_kind)
                    K_INSERT: begin
                        r_hit  <= 1'b0;
                        r_ok   <= r_key;
                        r_oval <= r_val;
                        r_last <= 1'b1;
                        r_tf   <= r_full;
                    end
                    K_FIND: begin
                        r_hit  <= r_found;
                        r_ok   <= r_key;
                        r_oval <= r_found ? r_vals[r_pos[AW-1:0]] : 32'sd0;
                        r_last <= 1'b1;
                        r_tf   <= 1'b0;
                    end
                    default: begin
                        r_tf <= 1'b0;
                        if (r_idx < r_count && w_k <= r_high) begin
                            r_hit  <= 1'b1;
                            r_ok   <= w_k;
                            r_oval <= r_vals[r_idx[AW-1:0]];
                            r_last <= (r_nout == 6'(MAX_OUT - 1)) ||
                                      (r_idx + 1'b1 >= r_count) ||
                                      (r_keys[r_idx[AW-1:0] + 1'b1] > r_high);
                            r_idx  <= r_idx + 1'b1;
                            r_nout <= r_nout + 1'b1;
                        end else begin
                            r_hit  <= 1'b0;
                            r_ok   <= r_key;
                            r_oval <= 32'sd0;
                            r_last <= 1'b1;
                        end
                    end
                endcase
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ov;
    assign o_hit          = r_hit;
    assign o_out_key      = r_ok;
    assign o_out_value    = r_oval;
    assign o_last         = r_last;
    assign o_ordered_mode = r_mode;
    assign o_table_full   = r_tf;

`include "adaptive_key_value_range_table_macros.svh"
    `AKV_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "count over capacity")
    `AKV_ASSERT(a_mode_sticky, i_clk, i_rst_n, r_mode |=> r_mode, "mode left ordered")
    `AKV_ASSERT(a_busy_no_ready, i_clk, i_rst_n, (r_state != S_IDLE) |-> !o_ready, "ready while busy")
    `AKV_ASSERT(a_full_only_ins, i_clk, i_rst_n, (r_ov && r_tf) |-> r_kind == K_INSERT, "full on non-insert")
endmodule
